[hw/rtl/term_vector_similarity_macros.svh]
// Assertion macros shared by the checker of the term vector similarity block.
// Depends on nothing; included by the checker file only.
`ifndef TERM_VECTOR_SIMILARITY_MACROS_SVH
`define TERM_VECTOR_SIMILARITY_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TVS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("term_vector_similarity check failed");

// Check a property on every clock edge, reset included.
`define TVS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("term_vector_similarity reset check failed");

`endif

[hw/rtl/tvs_pkg.sv]
// Shared types, constants and width helpers of the term vector similarity block.
// Depends on nothing; imported by every module of the block.
package tvs_pkg;

    localparam int COUNT_BITS_DEF          = 16;
    localparam int TERM_INDEX_BITS_DEF     = 20;
    localparam int RATIO_FRACTION_BITS_DEF = 16;
    localparam int COUNT_W                 = 16;
    localparam int SCORE_W                 = 32;
    localparam int SUM_CAP_W               = 62;
    localparam logic [SCORE_W-1:0] EMPTY_DISTANCE = SCORE_W'(255);

    typedef enum logic [1:0] {
        MET_MANHATTAN = 2'd0,
        MET_DICE      = 2'd1,
        MET_COSINE    = 2'd2,
        MET_JACCARD   = 2'd3
    } t_metric;

    localparam t_metric METRIC_RESET = MET_COSINE;

    typedef enum logic [1:0] {
        OUT_EMPTY = 2'd0,
        OUT_DIST  = 2'd1,
        OUT_ZERO  = 2'd2,
        OUT_RATIO = 2'd3
    } t_out_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_EVAL,
        S_MUL,
        S_SQRT,
        S_LDR,
        S_CHK,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic     take;
        logic     acc;
        logic     eval;
        logic     mul;
        logic [1:0] mul_idx;
        logic     sqrt;
        logic     ldr;
        logic     div_init;
        logic     div;
        logic     load_out;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic    seen;
        logic    last;
        t_metric mode;
        logic    den_zero;
        logic    out_free;
    } t_stat;

    function automatic int f_abs_w(input int cb, input int tib);
        return (cb + tib > SUM_CAP_W) ? SUM_CAP_W : cb + tib;
    endfunction

    function automatic int f_prod_w(input int cb, input int tib);
        return (2 * cb + tib > SUM_CAP_W) ? SUM_CAP_W : 2 * cb + tib;
    endfunction

    // half width of a product sum, rounded up
    function automatic int f_half_w(input int cb, input int tib);
        return (f_prod_w(cb, tib) + 1) >> 1;
    endfunction

    // dividend width: numerator (one extra bit for dice) plus fraction bits
    function automatic int f_dvd_w(input int cb, input int tib, input int fb);
        return f_prod_w(cb, tib) + 1 + fb;
    endfunction

endpackage

[hw/rtl/tvs_ctrl.sv]
// Sequencer of the term vector similarity block: input handshake, step counts.
// Depends on tvs_pkg; drives the datapath tvs_dp through t_cmd.
module tvs_ctrl #(
    parameter int COUNT_BITS          = tvs_pkg::COUNT_BITS_DEF,
    parameter int TERM_INDEX_BITS     = tvs_pkg::TERM_INDEX_BITS_DEF,
    parameter int RATIO_FRACTION_BITS = tvs_pkg::RATIO_FRACTION_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tvs_pkg::t_stat i_stat,
    output tvs_pkg::t_cmd  o_cmd
);
    import tvs_pkg::*;

    localparam int SQ_N  = 2 * f_half_w(COUNT_BITS, TERM_INDEX_BITS);
    localparam int DVD_W = f_dvd_w(COUNT_BITS, TERM_INDEX_BITS, RATIO_FRACTION_BITS);
    localparam int CNT_W = $clog2(DVD_W);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_out_sel         r_sel, n_sel;
    logic             cnt_end;

    // end of the current multi-cycle step
    always_comb begin
        unique case (r_state)
            S_MUL:   cnt_end = (r_cnt == CNT_W'(3));
            S_SQRT:  cnt_end = (r_cnt == CNT_W'(SQ_N - 1));
            S_DIV:   cnt_end = (r_cnt == CNT_W'(DVD_W - 1));
            default: cnt_end = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_cnt   = '0;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_ACC;
            S_ACC:  n_state = i_stat.last ? S_EVAL : S_IDLE;
            S_EVAL: begin
                priority if (!i_stat.seen) begin
                    n_sel   = OUT_EMPTY;
                    n_state = S_OUT;
                end else if (i_stat.mode == MET_MANHATTAN) begin
                    n_sel   = OUT_DIST;
                    n_state = S_OUT;
                end else if (i_stat.mode == MET_COSINE) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_MUL: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (cnt_end) begin
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (cnt_end) begin
                    n_cnt   = '0;
                    n_state = S_LDR;
                end
            end
            S_LDR: n_state = S_CHK;
            S_CHK: begin
                if (i_stat.den_zero) begin
                    n_sel   = OUT_ZERO;
                    n_state = S_OUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (cnt_end) begin
                    n_cnt   = '0;
                    n_sel   = OUT_RATIO;
                    n_state = S_OUT;
                end
            end
            S_OUT:  if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.take     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.acc      = (r_state == S_ACC);
        o_cmd.eval     = (r_state == S_EVAL);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.mul_idx  = r_cnt[1:0];
        o_cmd.sqrt     = (r_state == S_SQRT);
        o_cmd.ldr      = (r_state == S_LDR);
        o_cmd.div_init = (r_state == S_CHK);
        o_cmd.div      = (r_state == S_DIV);
        o_cmd.load_out = (r_state == S_OUT) && i_stat.out_free;
        o_cmd.out_sel  = r_sel;
        o_in_stall     = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sel   <= OUT_EMPTY;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

endmodule

[hw/rtl/tvs_dp.sv]
// Datapath of the term vector similarity block: running sums, split multiply,
// bit-serial square root, restoring divider and output register. Uses tvs_pkg.
module tvs_dp #(
    parameter int COUNT_BITS          = tvs_pkg::COUNT_BITS_DEF,
    parameter int TERM_INDEX_BITS     = tvs_pkg::TERM_INDEX_BITS_DEF,
    parameter int RATIO_FRACTION_BITS = tvs_pkg::RATIO_FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tvs_pkg::t_cmd                 i_cmd,
    output tvs_pkg::t_stat                o_stat,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_wdata,
    input  logic [tvs_pkg::COUNT_W-1:0]   i_count_a,
    input  logic [tvs_pkg::COUNT_W-1:0]   i_count_b,
    input  logic                          i_term_valid,
    input  logic                          i_last_term,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tvs_pkg::SCORE_W-1:0]   o_score,
    output logic                          o_empty_pair,
    output logic                          o_zero_denominator,
    output logic                          o_distance_saturated
);
    import tvs_pkg::*;

    localparam int CB     = COUNT_BITS;
    localparam int FB     = RATIO_FRACTION_BITS;
    localparam int ABS_W  = f_abs_w(COUNT_BITS, TERM_INDEX_BITS);
    localparam int PROD_W = f_prod_w(COUNT_BITS, TERM_INDEX_BITS);
    localparam int H      = f_half_w(COUNT_BITS, TERM_INDEX_BITS);
    localparam int RAD_W  = 4 * H;
    localparam int ROOT_W = 2 * H;
    localparam int NUM_W  = PROD_W + 1;
    localparam int DEN_W  = PROD_W + 1;
    localparam int DVD_W  = f_dvd_w(COUNT_BITS, TERM_INDEX_BITS, RATIO_FRACTION_BITS);
    localparam int EXT_W  = (CB > COUNT_W) ? CB : COUNT_W;

    // configuration
    t_metric r_mode;

    // accepted item
    logic [CB-1:0]   cnt_a, cnt_b;
    logic [EXT_W-1:0] ext_a, ext_b;
    logic [CB-1:0]   r_diff;
    logic [2*CB-1:0] r_pab, r_paa, r_pbb;
    logic            r_vld, r_last;

    // running sums
    logic [ABS_W-1:0]  r_abs;
    logic [PROD_W-1:0] r_dot, r_sa, r_sb;
    logic              r_seen;
    logic [ABS_W:0]    abs_add;
    logic [PROD_W:0]   dot_add, sa_add, sb_add;

    // ratio operands
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] sum_sq, dot_ext;

    // product of the square sums and its root
    logic [RAD_W-1:0]    r_rad;
    logic [ROOT_W-1:0]   r_root;
    logic [ROOT_W+1:0]   r_srem;
    logic [2*H-1:0]      sa_pad, sb_pad;
    logic [H-1:0]        mul_x, mul_y;
    logic [2*H-1:0]      mul_p;
    logic [RAD_W-1:0]    mul_sh;
    logic [ROOT_W+3:0]   sq_rem, sq_trial;
    logic                sq_ge;

    // divider
    logic [DVD_W-1:0]   r_dvd;
    logic [DEN_W:0]     r_drem;
    logic [DEN_W:0]     dv_rem;
    logic               dv_ge;
    logic [SCORE_W-1:0] r_q;
    logic               r_over;

    // output register
    logic               r_out_vld;
    logic [SCORE_W-1:0] r_score, n_score;
    logic               r_empty, r_zero, r_sat;
    logic               n_empty, n_zero, n_sat;
    logic [63:0]        abs64;

    assign ext_a = EXT_W'(i_count_a);
    assign ext_b = EXT_W'(i_count_b);
    assign cnt_a = ext_a[CB-1:0];
    assign cnt_b = ext_b[CB-1:0];

    // hold the metric select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= METRIC_RESET;
        end else if (i_cfg_we) begin
            r_mode <= t_metric'(i_cfg_wdata);
        end
    end

    // capture the term pair and its products
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_diff <= (cnt_a > cnt_b) ? cnt_a - cnt_b : cnt_b - cnt_a;
            r_pab  <= (2*CB)'(cnt_a) * (2*CB)'(cnt_b);
            r_paa  <= (2*CB)'(cnt_a) * (2*CB)'(cnt_a);
            r_pbb  <= (2*CB)'(cnt_b) * (2*CB)'(cnt_b);
            r_vld  <= i_term_valid;
            r_last <= i_last_term;
        end
    end

    // saturating running sums
    assign abs_add = {1'b0, r_abs} + (ABS_W+1)'(r_diff);
    assign dot_add = {1'b0, r_dot} + (PROD_W+1)'(r_pab);
    assign sa_add  = {1'b0, r_sa}  + (PROD_W+1)'(r_paa);
    assign sb_add  = {1'b0, r_sb}  + (PROD_W+1)'(r_pbb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_abs  <= '0;
            r_dot  <= '0;
            r_sa   <= '0;
            r_sb   <= '0;
            r_seen <= 1'b0;
        end else if (i_cmd.acc && r_vld) begin
            r_abs  <= abs_add[ABS_W]  ? '1 : abs_add[ABS_W-1:0];
            r_dot  <= dot_add[PROD_W] ? '1 : dot_add[PROD_W-1:0];
            r_sa   <= sa_add[PROD_W]  ? '1 : sa_add[PROD_W-1:0];
            r_sb   <= sb_add[PROD_W]  ? '1 : sb_add[PROD_W-1:0];
            r_seen <= 1'b1;
        end
    end

    // numerator and denominator per metric
    assign sum_sq  = NUM_W'(r_sa) + NUM_W'(r_sb);
    assign dot_ext = NUM_W'(r_dot);

    // one partial product of sa * sb per step
    assign sa_pad = (2*H)'(r_sa);
    assign sb_pad = (2*H)'(r_sb);
    assign mul_x  = i_cmd.mul_idx[0] ? sa_pad[2*H-1:H] : sa_pad[H-1:0];
    assign mul_y  = i_cmd.mul_idx[1] ? sb_pad[2*H-1:H] : sb_pad[H-1:0];
    assign mul_p  = (2*H)'(mul_x) * (2*H)'(mul_y);

    always_comb begin
        unique case (i_cmd.mul_idx)
            2'd0:    mul_sh = RAD_W'(mul_p);
            2'd3:    mul_sh = RAD_W'(mul_p) << (2 * H);
            default: mul_sh = RAD_W'(mul_p) << H;
        endcase
    end

    // one root bit per step
    assign sq_rem   = {r_srem, r_rad[RAD_W-1:RAD_W-2]};
    assign sq_trial = (ROOT_W+4)'({r_root, 2'b01});
    assign sq_ge    = (sq_rem >= sq_trial);

    // one quotient bit per step
    assign dv_rem = {r_drem[DEN_W-1:0], r_dvd[DVD_W-1]};
    assign dv_ge  = (dv_rem >= (DEN_W+1)'(r_den));

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_rad  <= '0;
            r_root <= '0;
            r_srem <= '0;
            unique case (r_mode)
                MET_DICE: begin
                    r_num <= {r_dot, 1'b0};
                    r_den <= sum_sq;
                end
                MET_JACCARD: begin
                    r_num <= dot_ext;
                    r_den <= (sum_sq > dot_ext) ? sum_sq - dot_ext : '0;
                end
                default: begin
                    r_num <= dot_ext;
                    r_den <= '0;
                end
            endcase
        end
        if (i_cmd.mul) begin
            r_rad <= r_rad + mul_sh;
        end
        if (i_cmd.sqrt) begin
            r_rad  <= r_rad << 2;
            r_srem <= sq_ge ? (ROOT_W+2)'(sq_rem - sq_trial) : (ROOT_W+2)'(sq_rem);
            r_root <= {r_root[ROOT_W-2:0], sq_ge};
        end
        if (i_cmd.ldr) begin
            r_den <= DEN_W'(r_root);
        end
        if (i_cmd.div_init) begin
            r_dvd  <= {r_num, FB'(0)};
            r_drem <= '0;
            r_q    <= '0;
            r_over <= 1'b0;
        end
        if (i_cmd.div) begin
            r_dvd  <= r_dvd << 1;
            r_drem <= dv_ge ? dv_rem - (DEN_W+1)'(r_den) : dv_rem;
            r_over <= r_over | r_q[SCORE_W-1];
            r_q    <= {r_q[SCORE_W-2:0], dv_ge};
        end
    end

    // select the result
    assign abs64 = 64'(r_abs);

    always_comb begin
        n_score = '0;
        n_empty = 1'b0;
        n_zero  = 1'b0;
        n_sat   = 1'b0;
        unique case (i_cmd.out_sel)
            OUT_EMPTY: begin
                n_empty = 1'b1;
                n_score = (r_mode == MET_MANHATTAN) ? EMPTY_DISTANCE : '0;
            end
            OUT_DIST: begin
                n_sat   = |abs64[63:SCORE_W];
                n_score = n_sat ? '1 : abs64[SCORE_W-1:0];
            end
            OUT_ZERO:  n_zero  = 1'b1;
            OUT_RATIO: n_score = r_over ? '1 : r_q;
            default:   n_score = '0;
        endcase
    end

    // output register, freed on a completed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_score <= n_score;
            r_empty <= n_empty;
            r_zero  <= n_zero;
            r_sat   <= n_sat;
        end
    end

    assign o_out_valid          = r_out_vld;
    assign o_score              = r_score;
    assign o_empty_pair         = r_empty;
    assign o_zero_denominator   = r_zero;
    assign o_distance_saturated = r_sat;

    assign o_stat.seen     = r_seen;
    assign o_stat.last     = r_last;
    assign o_stat.mode     = r_mode;
    assign o_stat.den_zero = (r_den == '0);
    assign o_stat.out_free = !r_out_vld || !i_out_stall;

endmodule

[hw/rtl/term_vector_similarity.sv]
// Term vector similarity block: top level joining tvs_ctrl and tvs_dp.
// Depends on tvs_pkg, tvs_ctrl and tvs_dp.
//
// Input channel (i_in_valid / o_in_stall) carries one aligned term pair per
// transaction: i_count_a, i_count_b, i_term_valid, i_last_term. Each item is
// captured with its products and then accumulated with saturation before the
// next is taken. On the last item one result leaves on the output channel
// (o_out_valid / i_out_stall): o_score with its empty, zero-denominator and
// saturation flags. Manhattan or an empty pair then go straight to the output;
// dice and jaccard check the denominator, then run the one-bit-per-cycle
// divider; cosine first adds 4 multiply steps, one root bit per cycle and a
// root load. A finished result sits in the output register while new items
// are taken; if it is still stalled when the next result is ready, the block
// holds. i_cfg_we writes the metric (0 manhattan, 1 dice, 2 cosine, 3 jaccard);
// the user must write it only while idle, which the block does not enforce.
// Synchronous reset clears the sums, selects cosine and drops o_out_valid.
module term_vector_similarity #(
    parameter int COUNT_BITS          = tvs_pkg::COUNT_BITS_DEF,
    parameter int TERM_INDEX_BITS     = tvs_pkg::TERM_INDEX_BITS_DEF,
    parameter int RATIO_FRACTION_BITS = tvs_pkg::RATIO_FRACTION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [tvs_pkg::COUNT_W-1:0] i_count_a,
    input  logic [tvs_pkg::COUNT_W-1:0] i_count_b,
    input  logic                        i_term_valid,
    input  logic                        i_last_term,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [tvs_pkg::SCORE_W-1:0] o_score,
    output logic                        o_empty_pair,
    output logic                        o_zero_denominator,
    output logic                        o_distance_saturated
);
    import tvs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    tvs_ctrl #(
        .COUNT_BITS          (COUNT_BITS),
        .TERM_INDEX_BITS     (TERM_INDEX_BITS),
        .RATIO_FRACTION_BITS (RATIO_FRACTION_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tvs_dp #(
        .COUNT_BITS          (COUNT_BITS),
        .TERM_INDEX_BITS     (TERM_INDEX_BITS),
        .RATIO_FRACTION_BITS (RATIO_FRACTION_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_count_a            (i_count_a),
        .i_count_b            (i_count_b),
        .i_term_valid         (i_term_valid),
        .i_last_term          (i_last_term),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_score              (o_score),
        .o_empty_pair         (o_empty_pair),
        .o_zero_denominator   (o_zero_denominator),
        .o_distance_saturated (o_distance_saturated)
    );

endmodule

[hw/rtl/tvs_checker.sv]
// Port-level checks of the term vector similarity block, bound to its top.
// Depends on term_vector_similarity_macros.svh.
`include "term_vector_similarity_macros.svh"

module tvs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_score,
    input logic        o_empty_pair,
    input logic        o_zero_denominator,
    input logic        o_distance_saturated
);

    // reset drops the result
    `TVS_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid)

    // stalled result holds
    `TVS_ASSERT(a_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_score))

    // an empty pair raises no other flag
    `TVS_ASSERT(a_empty_alone, i_clk, i_rst_n,
        o_out_valid && o_empty_pair |-> !o_zero_denominator && !o_distance_saturated)

    // zero denominator forces a zero score
    `TVS_ASSERT(a_zero_score, i_clk, i_rst_n,
        o_out_valid && o_zero_denominator |-> o_score == 32'd0 && !o_distance_saturated)

    // clamped distance reads all ones
    `TVS_ASSERT(a_sat_score, i_clk, i_rst_n,
        o_out_valid && o_distance_saturated |-> o_score == 32'hFFFF_FFFF)

endmodule

bind term_vector_similarity tvs_checker u_tvs_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_score              (o_score),
    .o_empty_pair         (o_empty_pair),
    .o_zero_denominator   (o_zero_denominator),
    .o_distance_saturated (o_distance_saturated)
);

[sim/tb.sv]
// Testbench of term_vector_similarity: directed table, then random document pairs.
// Depends on tvs_pkg and the term_vector_similarity RTL; checks with its own predictor.
`timescale 1ns / 1ps

module tb;
    import tvs_pkg::*;

    localparam int          DRAIN_CYCLES = 200;
    localparam longint      CYCLE_LIMIT  = 1500000;
    localparam logic [63:0] ABS_MAX      = (64'd1 << 36) - 1;
    localparam logic [63:0] PROD_MAX     = (64'd1 << 52) - 1;
    localparam logic [31:0] SCORE_TOP    = 32'hFFFF_FFFF;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    typedef struct {
        logic [31:0] score;
        bit          empty;
        bit          zero_den;
        bit          sat;
    } t_score;

    typedef struct {
        t_metric     mode;
        int          rep;
        logic [15:0] a;
        logic [15:0] b;
        bit          tv;
        bit          last;
        bit          typed;
        t_score      res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_count_a = '0;
    logic [15:0] i_count_b = '0;
    logic        i_term_valid = 1'b0;
    logic        i_last_term = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_score;
    logic        o_empty_pair;
    logic        o_zero_denominator;
    logic        o_distance_saturated;

    term_vector_similarity dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_count_a(i_count_a), .i_count_b(i_count_b),
        .i_term_valid(i_term_valid), .i_last_term(i_last_term),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_score(o_score), .o_empty_pair(o_empty_pair),
        .o_zero_denominator(o_zero_denominator),
        .o_distance_saturated(o_distance_saturated)
    );

    // predictor state
    logic [63:0] diff_acc, dot_acc, sq_a_acc, sq_b_acc;
    bit          term_seen;
    t_metric     cur_metric = METRIC_RESET;

    t_score      score_q[$];
    int          mismatches = 0;
    longint      cycles = 0;
    t_idle       idle_mode = IDLE_NONE;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // abort on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (idle_mode == IDLE_RECV)
            i_out_stall <= ($urandom_range(99) < 71);
        else if (idle_mode == IDLE_BOTH)
            i_out_stall <= ($urandom_range(99) < 22);
        else
            i_out_stall <= 1'b0;
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_score want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (score_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result score=%h", o_score);
            end else begin
                want = score_q.pop_front();
                if (o_score !== want.score || o_empty_pair !== want.empty ||
                    o_zero_denominator !== want.zero_den ||
                    o_distance_saturated !== want.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%b/%b/%b got %h/%b/%b/%b",
                                 want.score, want.empty, want.zero_den, want.sat,
                                 o_score, o_empty_pair, o_zero_denominator,
                                 o_distance_saturated);
                end
            end
        end
    end

    // append one expected result at the tail of the queue
    function automatic void expect_score(t_score s);
        score_q = {score_q, s};
    endfunction

    function automatic logic [63:0] sat_sum(logic [63:0] acc, logic [63:0] v,
                                            logic [63:0] cap);
        if (acc >= cap || cap - acc < v) return cap;
        return acc + v;
    endfunction

    function automatic logic [63:0] root_floor(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  cand;
        r = '0;
        for (int bitpos = 63; bitpos >= 0; bitpos--) begin
            cand = r | (64'd1 << bitpos);
            if ({64'd0, cand} * {64'd0, cand} <= n) r = cand;
        end
        return r;
    endfunction

    function automatic logic [31:0] q16_ratio(logic [63:0] num, logic [63:0] den);
        logic [127:0] q;
        q = ({64'd0, num} << 16) / {64'd0, den};
        return (q > {96'd0, SCORE_TOP}) ? SCORE_TOP : q[31:0];
    endfunction

    // advance the running sums; return 1 with the score when the pair closes
    function automatic bit similarity_step(logic [15:0] a, logic [15:0] b, bit tv,
                                           bit last, output t_score res);
        logic [63:0] sum_sq, den, num;
        res = '{score: '0, empty: 0, zero_den: 0, sat: 0};
        if (tv) begin
            diff_acc = sat_sum(diff_acc, (a > b) ? 64'(a - b) : 64'(b - a), ABS_MAX);
            dot_acc  = sat_sum(dot_acc, 64'(a) * 64'(b), PROD_MAX);
            sq_a_acc = sat_sum(sq_a_acc, 64'(a) * 64'(a), PROD_MAX);
            sq_b_acc = sat_sum(sq_b_acc, 64'(b) * 64'(b), PROD_MAX);
            term_seen = 1;
        end
        if (!last) return 0;
        sum_sq = sq_a_acc + sq_b_acc;
        num = dot_acc;
        den = '0;
        if (!term_seen) begin
            res.empty = 1;
            res.score = (cur_metric == MET_MANHATTAN) ? EMPTY_DISTANCE : '0;
        end else if (cur_metric == MET_MANHATTAN) begin
            res.sat   = diff_acc > {32'd0, SCORE_TOP};
            res.score = res.sat ? SCORE_TOP : diff_acc[31:0];
        end else begin
            case (cur_metric)
                MET_DICE: begin
                    num = dot_acc << 1;
                    den = sum_sq;
                end
                MET_COSINE: den = root_floor({64'd0, sq_a_acc} * {64'd0, sq_b_acc});
                default:    den = (sum_sq > dot_acc) ? sum_sq - dot_acc : '0;
            endcase
            if (den == 0) res.zero_den = 1;
            else res.score = q16_ratio(num, den);
        end
        diff_acc = '0;
        dot_acc = '0;
        sq_a_acc = '0;
        sq_b_acc = '0;
        term_seen = 0;
        return 1;
    endfunction

    // hand one transaction to the block, with random gaps before it
    task automatic send_term(logic [15:0] a, logic [15:0] b, bit tv, bit last,
                             bit typed, t_score typed_res);
        t_score res;
        int     gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 71 : (idle_mode == IDLE_BOTH) ? 22 : 0;
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_count_a    <= a;
        i_count_b    <= b;
        i_term_valid <= tv;
        i_last_term  <= last;
        do @(posedge i_clk); while (o_in_stall);
        if (similarity_step(a, b, tv, last, res))
            expect_score(typed ? typed_res : res);
    endtask

    // drain, let the block settle, then write the metric
    task automatic set_metric(t_metric m);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (score_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_metric = m;
    endtask

    function automatic logic [15:0] rand_count(int kind);
        case (kind)
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(15));
            2:       return 16'd0;
            default: return 16'hFFFF;
        endcase
    endfunction

    t_row rows[16];

    initial begin
        t_score none;
        int     sent, nterms, kind_a, kind_b;
        none = '{score: '0, empty: 0, zero_den: 0, sat: 0};
        rows = '{
            // empty pair under the reset metric
            '{MET_COSINE, 0, 16'h0, 16'h0, 0, 1, 1, '{32'd0, 1, 0, 0}},
            '{MET_MANHATTAN, 0, 16'hFFFF, 16'hFFFF, 0, 1, 1, '{32'd255, 1, 0, 0}},
            '{MET_MANHATTAN, 0, 16'hFFFF, 16'h0, 1, 1, 1, '{32'd65535, 0, 0, 0}},
            '{MET_MANHATTAN, 0, 16'h0, 16'h0, 1, 1, 1, '{32'd0, 0, 0, 0}},
            // zero denominators
            '{MET_DICE, 0, 16'h0, 16'h0, 1, 1, 1, '{32'd0, 0, 1, 0}},
            '{MET_DICE, 0, 16'h0, 16'h0, 0, 1, 1, '{32'd0, 1, 0, 0}},
            '{MET_DICE, 0, 16'hFFFF, 16'hFFFF, 1, 1, 1, '{32'd65536, 0, 0, 0}},
            '{MET_COSINE, 0, 16'h0, 16'h5, 1, 1, 1, '{32'd0, 0, 1, 0}},
            '{MET_COSINE, 0, 16'h7, 16'h7, 1, 1, 1, '{32'd65536, 0, 0, 0}},
            '{MET_COSINE, 0, 16'h3, 16'h4, 1, 0, 0, '{32'd0, 0, 0, 0}},
            '{MET_COSINE, 0, 16'h4, 16'h3, 1, 1, 0, '{32'd0, 0, 0, 0}},
            '{MET_JACCARD, 0, 16'h0, 16'h0, 1, 1, 1, '{32'd0, 0, 1, 0}},
            '{MET_JACCARD, 0, 16'h3, 16'h3, 1, 1, 1, '{32'd65536, 0, 0, 0}},
            // ignored item between terms
            '{MET_JACCARD, 0, 16'hAAAA, 16'h5555, 0, 0, 0, '{32'd0, 0, 0, 0}},
            '{MET_JACCARD, 0, 16'h5, 16'h0, 1, 1, 0, '{32'd0, 0, 0, 0}},
            '{MET_JACCARD, 0, 16'hFFFF, 16'h1, 1, 1, 0, '{32'd0, 0, 0, 0}}
        };
        diff_acc = '0;
        dot_acc = '0;
        sq_a_acc = '0;
        sq_b_acc = '0;
        term_seen = 0;

        // hold reset
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed table
        foreach (rows[i]) begin
            if (rows[i].mode != cur_metric) set_metric(rows[i].mode);
            repeat (rows[i].rep)
                send_term(rows[i].a, rows[i].b, rows[i].tv, 0, 0, none);
            send_term(rows[i].a, rows[i].b, rows[i].tv, rows[i].last,
                      rows[i].typed, rows[i].res);
        end

        // random document pairs, one metric and idle pattern per phase
        for (int ph = 0; ph < 8; ph++) begin
            set_metric(t_metric'(ph % 4));
            idle_mode = t_idle'((ph >> 1) % 4);
            sent = 0;
            while (sent < 50) begin
                nterms = $urandom_range(6);
                for (int t = 0; t < nterms; t++) begin
                    if ($urandom_range(7) == 0) begin
                        send_term(16'($urandom), 16'($urandom), 0, 0, 0, none);
                        sent++;
                    end
                    kind_a = $urandom_range(3);
                    kind_b = $urandom_range(3);
                    send_term(rand_count(kind_a), rand_count(kind_b), 1,
                              (t == nterms - 1) && ($urandom_range(5) != 0), 0, none);
                    sent++;
                end
                // close the pair unless the last term already did
                if (nterms == 0 || i_last_term == 1'b0) begin
                    send_term(16'($urandom), 16'($urandom), 0, 1, 0, none);
                    sent++;
                end
            end
        end

        // drain and finish
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (score_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[term_vector_similarity.f]
+incdir+hw/rtl
hw/rtl/tvs_pkg.sv
hw/rtl/tvs_ctrl.sv
hw/rtl/tvs_dp.sv
hw/rtl/term_vector_similarity.sv
hw/rtl/tvs_checker.sv
sim/tb.sv
